>>> rtl/ddpc_pkg.sv
// Package for the differential drive PID controller.
// Holds field widths, control constants, register indexes and shared types.
// No dependencies.
package ddpc_pkg;

    // Port and field widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int BASE_W     = 12;
    localparam int GAIN_W     = 16;
    localparam int SPEED_W    = 16;
    localparam int PWM_W      = 14;

    // Shared multiply-accumulate unit widths
    localparam int MUL_W  = 26;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KI     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_KP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_KD     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_ENABLE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_ENABLE = 3'd7;

    // Register reset values
    localparam logic [GAIN_W-1:0] SPEED_KP_RST = 16'd250;
    localparam logic [GAIN_W-1:0] SPEED_KD_RST = 16'd40;
    localparam logic [GAIN_W-1:0] STEER_KP_RST = 16'd2048;
    localparam logic [GAIN_W-1:0] STEER_KD_RST = 16'd6400;

    // Control constants
    localparam logic signed [PWM_W-1:0] DEADBAND = 14'sd3500;
    localparam logic signed [PWM_W-1:0] OUT_MIN  = -14'sd4000;
    localparam logic signed [PWM_W-1:0] OUT_MAX  = 14'sd7199;
    localparam logic signed [PWM_W-1:0] SLEW     = 14'sd800;
    localparam logic signed [10:0]      INT_LIM  = 11'sd800;

    // Turn factor cap (8.0 in Q16) and the magnitude at which it is reached
    localparam logic [19:0] K_CAP   = 20'd524288;
    localparam logic [31:0] MAG_CAP = 32'd800;
    // Inner scale floor (-0.3 in Q16)
    localparam logic signed [17:0] INNER_FLOOR = -18'sd19660;
    localparam logic [21:0]        Q16_ONE     = 22'd65536;

    // Reciprocals: x/25 exact for x < 2^24 with shift 29, y/5 exact for y < 2^21 with shift 24
    localparam logic [MUL_W-1:0] RECIP_25 = 26'd21474837;
    localparam logic [MUL_W-1:0] RECIP_5  = 26'd3355444;

    typedef struct packed {
        logic [BASE_W-1:0] base_speed;
        logic [GAIN_W-1:0] speed_kp;
        logic [GAIN_W-1:0] speed_ki;
        logic [GAIN_W-1:0] speed_kd;
        logic [GAIN_W-1:0] steer_kp;
        logic [GAIN_W-1:0] steer_kd;
        logic              steer_enable;
        logic              drive_enable;
    } cfg_t;

    typedef struct packed {
        logic issue;   // start a multiply this cycle
        logic first;   // product starts a new sum
    } mac_ctl_t;

endpackage

>>> rtl/ddpc_cfg.sv
// Configuration register file of the differential drive PID controller.
// Depends on ddpc_pkg for register indexes, reset values and cfg_t.
module ddpc_cfg
    import ddpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // Write one register per enabled cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_speed   <= '0;
            cfg_reg.speed_kp     <= SPEED_KP_RST;
            cfg_reg.speed_ki     <= '0;
            cfg_reg.speed_kd     <= SPEED_KD_RST;
            cfg_reg.steer_kp     <= STEER_KP_RST;
            cfg_reg.steer_kd     <= STEER_KD_RST;
            cfg_reg.steer_enable <= 1'b0;
            cfg_reg.drive_enable <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE_SPEED:   cfg_reg.base_speed   <= cfg_data[BASE_W-1:0];
                CFG_SPEED_KP:     cfg_reg.speed_kp     <= cfg_data[GAIN_W-1:0];
                CFG_SPEED_KI:     cfg_reg.speed_ki     <= cfg_data[GAIN_W-1:0];
                CFG_SPEED_KD:     cfg_reg.speed_kd     <= cfg_data[GAIN_W-1:0];
                CFG_STEER_KP:     cfg_reg.steer_kp     <= cfg_data[GAIN_W-1:0];
                CFG_STEER_KD:     cfg_reg.steer_kd     <= cfg_data[GAIN_W-1:0];
                CFG_STEER_ENABLE: cfg_reg.steer_enable <= cfg_data[0];
                CFG_DRIVE_ENABLE: cfg_reg.drive_enable <= cfg_data[0];
                default:          cfg_reg.drive_enable <= cfg_reg.drive_enable;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/ddpc_mac.sv
// Shared multiply-accumulate unit: registered product, then registered sum.
// An issued product passes through prod_reg and then acc_reg before it is visible on acc.
// Depends on ddpc_pkg for widths and mac_ctl_t.
module ddpc_mac
    import ddpc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_ctl_t                ctl,
    input  logic signed [MUL_W-1:0] a,
    input  logic signed [MUL_W-1:0] b,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     p_vld_reg;
    logic                     p_first_reg;

    // Track which product stage holds a live product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg   <= 1'b0;
            p_first_reg <= 1'b0;
        end
        else
        begin
            p_vld_reg   <= ctl.issue;
            p_first_reg <= ctl.first;
        end
    end

    // Multiply, then fold the product into the running sum
    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            prod_reg <= a * b;
        end
        if (p_vld_reg)
        begin
            acc_reg <= (p_first_reg ? '0 : acc_reg) + ACC_W'(prod_reg);
        end
    end

    assign acc = acc_reg;

endmodule

>>> rtl/differential_drive_pid_controller.sv
// Differential drive controller: steering PD feeding two wheel speed PIDs.
// Steering on runs the steering steps first; a zero target skips that wheel's PID, and run
// low goes straight to the result; a stalled result holds the sequencer. A new word is taken
// only once the last result is loaded, as one shared multiplier is walked through up to 12
// products. Reset: asynchronous, active low; clears loop state, loads defaults.
// Depends on ddpc_pkg, ddpc_cfg and ddpc_mac.
module differential_drive_pid_controller
    import ddpc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     run,
    input  logic signed [SPEED_W-1:0] line_error,
    input  logic signed [SPEED_W-1:0] left_rate,
    input  logic signed [SPEED_W-1:0] right_rate,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [PWM_W-1:0]  channel_a_pwm,
    output logic signed [PWM_W-1:0]  channel_b_pwm,
    output logic                     pwm_valid
);

    // Sequencer states, in issue order
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_ST1  = 5'd1;
    localparam logic [4:0] S_ST2  = 5'd2;
    localparam logic [4:0] S_ST3  = 5'd3;
    localparam logic [4:0] S_ST4  = 5'd4;
    localparam logic [4:0] S_K1   = 5'd5;
    localparam logic [4:0] S_K2   = 5'd6;
    localparam logic [4:0] S_K3   = 5'd7;
    localparam logic [4:0] S_K4   = 5'd8;
    localparam logic [4:0] S_K5   = 5'd9;
    localparam logic [4:0] S_K6   = 5'd10;
    localparam logic [4:0] S_K7   = 5'd11;
    localparam logic [4:0] S_K8   = 5'd12;
    localparam logic [4:0] S_K9   = 5'd13;
    localparam logic [4:0] S_P1   = 5'd14;
    localparam logic [4:0] S_P2   = 5'd15;
    localparam logic [4:0] S_P3   = 5'd16;
    localparam logic [4:0] S_P4   = 5'd17;
    localparam logic [4:0] S_P5   = 5'd18;
    localparam logic [4:0] S_P6   = 5'd19;
    localparam logic [4:0] S_P7   = 5'd20;
    localparam logic [4:0] S_DONE = 5'd21;

    localparam logic signed [ACC_W-1:0] DB_HI   = ACC_W'(3699);
    localparam logic signed [ACC_W-1:0] DB_LO   = -ACC_W'(500);
    localparam logic signed [19:0]      ERR_MAX = 20'sd131071;
    localparam logic signed [19:0]      ERR_MIN = -20'sd131072;

    cfg_t                    cfg;
    mac_ctl_t                mac_ctl;
    logic signed [MUL_W-1:0] mac_a;
    logic signed [MUL_W-1:0] mac_b;
    logic signed [ACC_W-1:0] acc;

    logic [4:0] state_reg;
    logic       wheel_reg;
    logic       pv_reg;

    // Loop state
    logic signed [31:0]      steer_out_reg;
    logic signed [16:0]      steer_prev_reg;
    logic signed [10:0]      left_integral_reg;
    logic signed [10:0]      right_integral_reg;
    logic signed [17:0]      left_prev_reg;
    logic signed [17:0]      right_prev_reg;
    logic signed [PWM_W-1:0] left_ramp_reg;
    logic signed [PWM_W-1:0] right_ramp_reg;

    // Per-word working registers
    logic signed [16:0]        e_reg;
    logic signed [SPEED_W-1:0] lspd_reg;
    logic signed [SPEED_W-1:0] rspd_reg;
    logic [19:0]               k_reg;
    logic signed [17:0]        inner_reg;
    logic signed [18:0]        outer_t_reg;
    logic signed [18:0]        ltgt_reg;
    logic signed [18:0]        rtgt_reg;
    logic signed [17:0]        err_reg;
    logic signed [18:0]        diff_reg;
    logic signed [PWM_W-1:0]   pid_reg;

    // Output register
    logic                    out_valid_reg;
    logic signed [PWM_W-1:0] ch_a_reg;
    logic signed [PWM_W-1:0] ch_b_reg;
    logic                    pwm_valid_reg;

    logic accept;
    logic out_load;

    ddpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ddpc_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (acc)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Steering arithmetic
    logic signed [17:0]      e_diff;
    logic signed [ACC_W-1:0] steer_rnd;
    logic signed [31:0]      steer_new;
    logic [31:0]             steer_mag;
    logic                    mag_big;
    logic [23:0]             mag_x;
    logic [19:0]             k_calc;
    logic [21:0]             k3;
    logic [19:0]             q5;
    logic signed [20:0]      inner_raw;
    logic signed [17:0]      inner_next;
    logic [21:0]             outer_scale;
    logic signed [ACC_W-1:0] inner_rnd;
    logic signed [18:0]      inner_t;

    assign e_diff    = {e_reg[16], e_reg} - {steer_prev_reg[16], steer_prev_reg};
    assign steer_rnd = acc + $signed({{(ACC_W-8){1'b0}}, {8{acc[ACC_W-1]}}});
    assign steer_new = steer_rnd[39:8];
    assign steer_mag = steer_out_reg[31] ? 32'(-steer_out_reg) : 32'(steer_out_reg);
    assign mag_big   = (steer_mag >= MAG_CAP);
    assign mag_x     = {steer_mag[9:0], 14'd0};
    assign k_calc    = mag_big ? K_CAP : {1'b0, acc[47:29]};
    assign k3        = {2'b00, k_reg} + {1'b0, k_reg, 1'b0};
    assign q5        = acc[43:24];
    assign inner_raw = 21'sd65536 - $signed({1'b0, q5});
    assign inner_next = (inner_raw < 21'(INNER_FLOOR)) ? INNER_FLOOR : inner_raw[17:0];
    assign outer_scale = Q16_ONE + {k_reg, 2'b00};
    assign inner_rnd = acc + $signed({{(ACC_W-16){1'b0}}, {16{acc[ACC_W-1]}}});
    assign inner_t   = inner_rnd[34:16];

    // Wheel PID arithmetic, on the wheel in turn
    logic signed [18:0]        tgt_cur;
    logic signed [SPEED_W-1:0] meas_cur;
    logic signed [10:0]        integ_cur;
    logic signed [17:0]        prev_cur;
    logic signed [PWM_W-1:0]   ramp_cur;
    logic signed [19:0]        d20;
    logic signed [17:0]        err_sat;
    logic signed [18:0]        isum;
    logic signed [10:0]        integ_next;
    logic signed [PWM_W-1:0]   acc_lo;
    logic signed [PWM_W-1:0]   pid_next;
    logic signed [PWM_W-1:0]   ramp_next;
    logic                      tgt_zero;

    assign tgt_cur   = wheel_reg ? rtgt_reg : ltgt_reg;
    assign meas_cur  = wheel_reg ? rspd_reg : lspd_reg;
    assign integ_cur = wheel_reg ? right_integral_reg : left_integral_reg;
    assign prev_cur  = wheel_reg ? right_prev_reg : left_prev_reg;
    assign ramp_cur  = wheel_reg ? right_ramp_reg : left_ramp_reg;
    assign tgt_zero  = (tgt_cur == '0);

    assign d20 = {tgt_cur[18], tgt_cur} - {{4{meas_cur[SPEED_W-1]}}, meas_cur};

    // Saturate the speed error, then the integral
    always_comb
    begin
        if (d20 > ERR_MAX)
        begin
            err_sat = ERR_MAX[17:0];
        end
        else if (d20 < ERR_MIN)
        begin
            err_sat = ERR_MIN[17:0];
        end
        else
        begin
            err_sat = d20[17:0];
        end
        isum = {{8{integ_cur[10]}}, integ_cur} + {err_sat[17], err_sat};
        if (isum > 19'(INT_LIM))
        begin
            integ_next = INT_LIM;
        end
        else if (isum < -19'(INT_LIM))
        begin
            integ_next = -INT_LIM;
        end
        else
        begin
            integ_next = isum[10:0];
        end
    end

    // Deadband offset and output clamp
    assign acc_lo = acc[PWM_W-1:0];
    always_comb
    begin
        if (acc > DB_HI)
        begin
            pid_next = OUT_MAX;
        end
        else if (!acc[ACC_W-1] && (acc != '0))
        begin
            pid_next = acc_lo + DEADBAND;
        end
        else if (acc == '0)
        begin
            pid_next = '0;
        end
        else if (acc < DB_LO)
        begin
            pid_next = OUT_MIN;
        end
        else
        begin
            pid_next = acc_lo - DEADBAND;
        end
    end

    // Slew the ramp one step towards the PID output
    always_comb
    begin
        if (ramp_cur < pid_reg)
        begin
            ramp_next = ramp_cur + SLEW;
        end
        else if (ramp_cur > pid_reg)
        begin
            ramp_next = ramp_cur - SLEW;
        end
        else
        begin
            ramp_next = ramp_cur;
        end
    end

    // Select multiplier operands for the current step
    always_comb
    begin
        mac_ctl = '0;
        mac_a   = '0;
        mac_b   = '0;
        case (state_reg)
            S_ST1:
            begin
                mac_ctl = '{issue: 1'b1, first: 1'b1};
                mac_a   = $signed({{(MUL_W-GAIN_W){1'b0}}, cfg.steer_kp});
                mac_b   = MUL_W'(e_reg);
            end
            S_ST2:
            begin
                mac_ctl = '{issue: 1'b1, first: 1'b0};
                mac_a   = $signed({{(MUL_W-GAIN_W){1'b0}}, cfg.steer_kd});
                mac_b   = MUL_W'(e_diff);
            end
            S_K1:
            begin
                mac_ctl = '{issue: 1'b1, first: 1'b1};
                mac_a   = $signed({2'b00, mag_x});
                mac_b   = $signed(RECIP_25);
            end
            S_K4:
            begin
                mac_ctl = '{issue: 1'b1, first: 1'b1};
                mac_a   = $signed({4'b0000, k3});
                mac_b   = $signed(RECIP_5);
            end
            S_K5:
            begin
                mac_ctl = '{issue: 1'b1, first: 1'b1};
                mac_a   = $signed({{(MUL_W-BASE_W){1'b0}}, cfg.base_speed});
                mac_b   = $signed({4'b0000, outer_scale});
            end
            S_K7:
            begin
                mac_ctl = '{issue: 1'b1, first: 1'b1};
                mac_a   = $signed({{(MUL_W-BASE_W){1'b0}}, cfg.base_speed});
                mac_b   = MUL_W'(inner_reg);
            end
            S_P2:
            begin
                mac_ctl = '{issue: 1'b1, first: 1'b1};
                mac_a   = $signed({{(MUL_W-GAIN_W){1'b0}}, cfg.speed_kp});
                mac_b   = MUL_W'(err_reg);
            end
            S_P3:
            begin
                mac_ctl = '{issue: 1'b1, first: 1'b0};
                mac_a   = $signed({{(MUL_W-GAIN_W){1'b0}}, cfg.speed_ki});
                mac_b   = MUL_W'(integ_cur);
            end
            S_P4:
            begin
                mac_ctl = '{issue: 1'b1, first: 1'b0};
                mac_a   = $signed({{(MUL_W-GAIN_W){1'b0}}, cfg.speed_kd});
                mac_b   = MUL_W'(diff_reg);
            end
            default:
            begin
                mac_ctl = '0;
            end
        endcase
    end

    // Sequencer and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            wheel_reg          <= 1'b0;
            pv_reg             <= 1'b0;
            steer_out_reg      <= '0;
            steer_prev_reg     <= '0;
            left_integral_reg  <= '0;
            right_integral_reg <= '0;
            left_prev_reg      <= '0;
            right_prev_reg     <= '0;
            left_ramp_reg      <= '0;
            right_ramp_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        wheel_reg <= 1'b0;
                        if (!run)
                        begin
                            left_ramp_reg  <= '0;
                            right_ramp_reg <= '0;
                            pv_reg         <= 1'b1;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= cfg.steer_enable ? S_ST1 : S_K1;
                        end
                    end
                end
                S_ST4:
                begin
                    steer_out_reg  <= steer_new;
                    steer_prev_reg <= e_reg;
                    state_reg      <= S_K1;
                end
                S_P1:
                begin
                    // Zero target clears this wheel's loop and skips the PID
                    if (wheel_reg)
                    begin
                        right_integral_reg <= tgt_zero ? '0 : integ_next;
                        right_prev_reg     <= tgt_zero ? '0 : err_sat;
                    end
                    else
                    begin
                        left_integral_reg <= tgt_zero ? '0 : integ_next;
                        left_prev_reg     <= tgt_zero ? '0 : err_sat;
                    end
                    state_reg <= tgt_zero ? S_P7 : S_P2;
                end
                S_P7:
                begin
                    if (wheel_reg)
                    begin
                        right_ramp_reg <= ramp_next;
                        pv_reg         <= cfg.drive_enable;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        left_ramp_reg <= ramp_next;
                        wheel_reg     <= 1'b1;
                        state_reg     <= S_P1;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= state_reg + 5'd1;
                end
            endcase
        end
    end

    // Working registers for the word in progress
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    e_reg    <= -{line_error[SPEED_W-1], line_error};
                    lspd_reg <= left_rate;
                    rspd_reg <= right_rate;
                end
            end
            S_K3:    k_reg       <= k_calc;
            S_K6:    inner_reg   <= inner_next;
            S_K7:    outer_t_reg <= {1'b0, acc[33:16]};
            S_K9:
            begin
                // Left wheel is inner for a non-negative steering output
                if (steer_out_reg[31])
                begin
                    ltgt_reg <= outer_t_reg;
                    rtgt_reg <= inner_t;
                end
                else
                begin
                    ltgt_reg <= inner_t;
                    rtgt_reg <= outer_t_reg;
                end
            end
            S_P1:
            begin
                err_reg  <= err_sat;
                diff_reg <= {err_sat[17], err_sat} - {prev_cur[17], prev_cur};
                if (tgt_zero)
                begin
                    pid_reg <= '0;
                end
            end
            S_P6:    pid_reg     <= pid_next;
            default: pid_reg     <= pid_reg;
        endcase
    end

    // Output register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ch_a_reg      <= right_ramp_reg;
            ch_b_reg      <= left_ramp_reg;
            pwm_valid_reg <= pv_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign channel_a_pwm = ch_a_reg;
    assign channel_b_pwm = ch_b_reg;
    assign pwm_valid     = pwm_valid_reg;

    // A new word is never taken in the cycle after one was taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input taken twice in a row");

    // Integrators stay inside their clamp
    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        (left_integral_reg <= INT_LIM) && (left_integral_reg >= -INT_LIM) &&
        (right_integral_reg <= INT_LIM) && (right_integral_reg >= -INT_LIM))
        else $error("integrator outside clamp");

    // Left ramp moves by one slew step, holds, or clears
    a_left_slew: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (left_ramp_reg == $past(left_ramp_reg)) || (left_ramp_reg == '0) ||
                 (left_ramp_reg == $past(left_ramp_reg) + SLEW) ||
                 (left_ramp_reg == $past(left_ramp_reg) - SLEW))
        else $error("left ramp jumped");

    // Right ramp moves by one slew step, holds, or clears
    a_right_slew: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (right_ramp_reg == $past(right_ramp_reg)) || (right_ramp_reg == '0) ||
                 (right_ramp_reg == $past(right_ramp_reg) + SLEW) ||
                 (right_ramp_reg == $past(right_ramp_reg) - SLEW))
        else $error("right ramp jumped");

    // A result only appears after the sequencer finished a word
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside done state");

endmodule
